FILE: rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants of the base64 stream decoder
// Character codes, status codes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

	localparam int unsigned CharWidth   = 8;
	localparam int unsigned SextetWidth = 6;
	localparam int unsigned AccWidth    = 3 * SextetWidth;
	localparam int unsigned WordWidth   = 4 * SextetWidth;

	// status codes of a result
	localparam logic [1:0] STATUS_MORE  = 2'd0;
	localparam logic [1:0] STATUS_END   = 2'd1;
	localparam logic [1:0] STATUS_ERROR = 2'd2;

	// character codes
	localparam logic [7:0] CHAR_NUL     = 8'h00;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_PLUS    = 8'h2B;
	localparam logic [7:0] CHAR_MINUS   = 8'h2D;
	localparam logic [7:0] CHAR_SLASH   = 8'h2F;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

	// offsets that turn a character into its sextet
	localparam logic [7:0] LOWER_OFFSET = CHAR_LOWER_A - 8'd26;
	localparam logic [7:0] DIGIT_OFFSET = CHAR_ZERO - 8'd52;
	localparam logic [5:0] SEXTET_PLUS  = 6'd62;
	localparam logic [5:0] SEXTET_SLASH = 6'd63;

	localparam logic [1:0] LAST_SEXTET  = 2'd3;
	localparam logic [1:0] BYTES_FULL   = 2'd3;

	typedef struct packed {
		logic [7:0] byte_hi;
		logic [7:0] byte_mid;
		logic [7:0] byte_lo;
		logic [1:0] byte_count;
		logic [1:0] status;
	} b64d_result_t;

endpackage

`default_nettype wire

FILE: rtl/b64d_char_if.sv
// ----------------------------------------------------------------------------
// b64d_char_if: character request channel
// One encoded character and its start-of-body mark per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64d_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       first_of_body;

	modport source (output valid, output char_in, output first_of_body, input ready);
	modport sink   (input valid, input char_in, input first_of_body, output ready);
endinterface

`default_nettype wire

FILE: rtl/b64d_byte_if.sv
// ----------------------------------------------------------------------------
// b64d_byte_if: decoded byte request channel
// Up to three bytes of one quad with a count and a status per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64d_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_hi;
	logic [7:0] byte_mid;
	logic [7:0] byte_lo;
	logic [1:0] byte_count;
	logic [1:0] status;

	modport source (output valid, output byte_hi, output byte_mid, output byte_lo,
		output byte_count, output status, input ready);
	modport sink   (input valid, input byte_hi, input byte_mid, input byte_lo,
		input byte_count, input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/b64d_out_buf.sv
// ----------------------------------------------------------------------------
// b64d_out_buf: two-entry result buffer
// Holds finished results so the decoder keeps taking characters while the
// consumer stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_out_buf (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire b64d_pkg::b64d_result_t push_data,
	output logic                       full,
	b64d_byte_if.source                byte_stream
);

	b64d_pkg::b64d_result_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;
	b64d_pkg::b64d_result_t head;

	assign full = count_q[1];
	assign pop  = byte_stream.valid && byte_stream.ready;
	assign head = entry_q[rd_ptr_q];

	assign byte_stream.valid      = (count_q != 2'd0);
	assign byte_stream.byte_hi    = head.byte_hi;
	assign byte_stream.byte_mid   = head.byte_mid;
	assign byte_stream.byte_lo    = head.byte_lo;
	assign byte_stream.byte_count = head.byte_count;
	assign byte_stream.status     = head.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

FILE: rtl/base64_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder_core: streaming base64 body decoder
// Takes one character per clock and returns one result per completed quad,
// end or error. Each accepted character is handled in the cycle it arrives:
// the quad state (sextet count, 18-bit accumulator, pad count, halt flag)
// updates at the accepting edge and any result lands in a two-entry output
// buffer, so the rate is one character per cycle; the result is registered in
// that buffer at the accepting edge and reaches byte_stream from it. Characters 1..32
// are skipped, '=' pads count as zero sextets, and NUL, '=' or '-' at the
// start of a quad ends the body. After an end or error all characters are
// dropped until one arrives with first_of_body set. Bytes at or beyond
// byte_count read as zero. char_stream stalls only when both buffer entries
// hold results the consumer has not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_decoder_core (
	input  wire logic clk,
	input  wire logic arst_n,
	b64d_char_if.sink   char_stream,
	b64d_byte_if.source byte_stream
);

	// quad state
	logic [1:0]                      sextet_count_q;
	logic [b64d_pkg::AccWidth-1:0]   acc_q;
	logic [1:0]                      pad_count_q;
	logic                            halted_q;

	// state seen by this character once first_of_body has cleared it
	logic [1:0]                      cnt_cur;
	logic [b64d_pkg::AccWidth-1:0]   acc_cur;
	logic [1:0]                      pad_cur;
	logic                            halt_cur;

	logic [1:0]                      cnt_nxt;
	logic [b64d_pkg::AccWidth-1:0]   acc_nxt;
	logic [1:0]                      pad_nxt;
	logic                            halt_nxt;

	logic [7:0]                      c;
	logic [7:0]                      diff;
	logic [b64d_pkg::SextetWidth-1:0] sextet;
	logic                            is_sextet;
	logic                            is_stop;
	logic [1:0]                      stop_status;
	logic                            is_pad;
	logic [1:0]                      pad_sum;
	logic [b64d_pkg::WordWidth-1:0]  word;
	logic [1:0]                      quad_count;

	logic                            accept;
	logic                            has_result;
	logic                            buf_full;
	b64d_pkg::b64d_result_t          result;

	assign c      = char_stream.char_in;
	assign accept = char_stream.valid && char_stream.ready;
	assign char_stream.ready = !buf_full;

	// clear the quad ahead of the character when a new body starts
	always_comb begin
		if (char_stream.first_of_body) begin
			cnt_cur  = 2'd0;
			acc_cur  = '0;
			pad_cur  = 2'd0;
			halt_cur = 1'b0;
		end else begin
			cnt_cur  = sextet_count_q;
			acc_cur  = acc_q;
			pad_cur  = pad_count_q;
			halt_cur = halted_q;
		end
	end

	// classify the character
	always_comb begin
		diff        = 8'd0;
		sextet      = '0;
		is_sextet   = 1'b0;
		is_stop     = 1'b0;
		stop_status = b64d_pkg::STATUS_ERROR;
		is_pad      = 1'b0;
		if (c >= b64d_pkg::CHAR_UPPER_A && c <= b64d_pkg::CHAR_UPPER_Z) begin
			diff      = c - b64d_pkg::CHAR_UPPER_A;
			sextet    = diff[b64d_pkg::SextetWidth-1:0];
			is_sextet = 1'b1;
		end else if (c >= b64d_pkg::CHAR_LOWER_A && c <= b64d_pkg::CHAR_LOWER_Z) begin
			diff      = c - b64d_pkg::LOWER_OFFSET;
			sextet    = diff[b64d_pkg::SextetWidth-1:0];
			is_sextet = 1'b1;
		end else if (c >= b64d_pkg::CHAR_ZERO && c <= b64d_pkg::CHAR_NINE) begin
			diff      = c - b64d_pkg::DIGIT_OFFSET;
			sextet    = diff[b64d_pkg::SextetWidth-1:0];
			is_sextet = 1'b1;
		end else if (c == b64d_pkg::CHAR_PLUS) begin
			sextet    = b64d_pkg::SEXTET_PLUS;
			is_sextet = 1'b1;
		end else if (c == b64d_pkg::CHAR_SLASH) begin
			sextet    = b64d_pkg::SEXTET_SLASH;
			is_sextet = 1'b1;
		end else if (c == b64d_pkg::CHAR_EQUALS || c == b64d_pkg::CHAR_NUL) begin
			if (cnt_cur == 2'd0) begin
				// end of body at a quad boundary
				is_stop     = 1'b1;
				stop_status = b64d_pkg::STATUS_END;
			end else if (c == b64d_pkg::CHAR_NUL) begin
				is_stop = 1'b1;
			end else begin
				// pad counts as a zero sextet
				is_sextet = 1'b1;
				is_pad    = 1'b1;
			end
		end else if (c == b64d_pkg::CHAR_MINUS && cnt_cur == 2'd0) begin
			is_stop     = 1'b1;
			stop_status = b64d_pkg::STATUS_END;
		end else if (c > b64d_pkg::CHAR_SPACE) begin
			// anything else outside the alphabet is an error
			is_stop = 1'b1;
		end
		// remaining codes 1..32 are whitespace: skip
	end

	// pad count including this character
	assign pad_sum    = pad_cur + {1'b0, is_pad};
	assign word       = {acc_cur, sextet};
	assign quad_count = b64d_pkg::BYTES_FULL - pad_sum;

	// next state and result
	always_comb begin
		cnt_nxt    = cnt_cur;
		acc_nxt    = acc_cur;
		pad_nxt    = pad_sum;
		halt_nxt   = halt_cur;
		has_result = 1'b0;
		result     = '0;
		if (!halt_cur) begin
			if (is_stop) begin
				cnt_nxt       = 2'd0;
				acc_nxt       = '0;
				halt_nxt      = 1'b1;
				has_result    = 1'b1;
				result.status = stop_status;
			end else if (is_sextet) begin
				if (cnt_cur != b64d_pkg::LAST_SEXTET) begin
					cnt_nxt = cnt_cur + 2'd1;
					acc_nxt = word[b64d_pkg::AccWidth-1:0];
				end else begin
					// quad complete: emit the valid leading bytes
					cnt_nxt           = 2'd0;
					acc_nxt           = '0;
					has_result        = 1'b1;
					result.byte_count = quad_count;
					result.byte_hi    = (quad_count > 2'd0) ? word[23:16] : 8'd0;
					result.byte_mid   = (quad_count > 2'd1) ? word[15:8]  : 8'd0;
					result.byte_lo    = (quad_count > 2'd2) ? word[7:0]   : 8'd0;
					if (pad_sum != 2'd0) begin
						result.status = b64d_pkg::STATUS_END;
						halt_nxt      = 1'b1;
					end else begin
						result.status = b64d_pkg::STATUS_MORE;
					end
				end
			end
			// a stop or a completed quad starts a fresh pad count
			if (is_stop || (is_sextet && cnt_cur == b64d_pkg::LAST_SEXTET))
				pad_nxt = 2'd0;
		end else begin
			pad_nxt = pad_cur;
		end
	end

	// advance the quad state on every accepted character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sextet_count_q <= 2'd0;
			acc_q          <= '0;
			pad_count_q    <= 2'd0;
			halted_q       <= 1'b0;
		end else if (accept) begin
			sextet_count_q <= cnt_nxt;
			acc_q          <= acc_nxt;
			pad_count_q    <= pad_nxt;
			halted_q       <= halt_nxt;
		end
	end

	b64d_out_buf u_out_buf (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (accept && has_result),
		.push_data   (result),
		.full        (buf_full),
		.byte_stream (byte_stream)
	);

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for base64_stream_decoder_core
// Streams directed and random character bodies through the decoder, predicts
// every quad, end and error result, and checks each returned byte request
// field by field while both channels stall and idle at random.
// ----------------------------------------------------------------------------

module testbench;

	localparam int unsigned RANDOM_CHARS = 400;
	localparam int unsigned IDLE_LIMIT   = 2000;
	localparam int unsigned LONG_HOLD    = 300;
	localparam int unsigned HOLD_AFTER   = 60;
	localparam int unsigned DRAIN_CYCLES = 10;
	localparam logic [7:0]  CHAR_SOH     = 8'h01;
	localparam logic [7:0]  CHAR_MAX     = 8'hFF;

	typedef struct packed {
		logic [7:0] code;
		logic       first;
	} char_req_t;

	// Tracks the quad state of the decoder and the byte requests it owes.
	class quad_scoreboard;
		logic [1:0]   sextets;
		logic [17:0]  acc;
		logic [1:0]   pads;
		bit           halted;
		b64d_pkg::b64d_result_t owed_q[$];
		int unsigned  live_chars;
		int unsigned  fail_count;

		function new();
			sextets    = '0;
			acc        = '0;
			pads       = '0;
			halted     = 1'b0;
			live_chars = 0;
			fail_count = 0;
		endfunction

		function void clear_quad();
			sextets = '0;
			acc     = '0;
			pads    = '0;
		endfunction

		// End or error: zero bytes, then ignore input until the next body.
		function void stop_body(logic [1:0] st);
			b64d_pkg::b64d_result_t r;
			r        = '0;
			r.status = st;
			halted   = 1'b1;
			clear_quad();
			owed_q.push_back(r);
		endfunction

		function void note_char(logic [7:0] c, logic first);
			logic [5:0]   sx;
			logic [23:0]  word;
			logic [1:0]   cnt;
			b64d_pkg::b64d_result_t r;
			if (first) begin
				clear_quad();
				halted = 1'b0;
			end
			if (halted)
				return;
			live_chars++;
			if (c >= b64d_pkg::CHAR_UPPER_A && c <= b64d_pkg::CHAR_UPPER_Z) begin
				sx = 6'(c - b64d_pkg::CHAR_UPPER_A);
			end else if (c >= b64d_pkg::CHAR_LOWER_A && c <= b64d_pkg::CHAR_LOWER_Z) begin
				sx = 6'(c - b64d_pkg::LOWER_OFFSET);
			end else if (c >= b64d_pkg::CHAR_ZERO && c <= b64d_pkg::CHAR_NINE) begin
				sx = 6'(c - b64d_pkg::DIGIT_OFFSET);
			end else if (c == b64d_pkg::CHAR_PLUS) begin
				sx = b64d_pkg::SEXTET_PLUS;
			end else if (c == b64d_pkg::CHAR_SLASH) begin
				sx = b64d_pkg::SEXTET_SLASH;
			end else if (c == b64d_pkg::CHAR_EQUALS || c == b64d_pkg::CHAR_NUL) begin
				if (sextets == '0) begin
					stop_body(b64d_pkg::STATUS_END);
					return;
				end
				if (c == b64d_pkg::CHAR_NUL) begin
					stop_body(b64d_pkg::STATUS_ERROR);
					return;
				end
				sx   = '0;
				pads = pads + 2'd1;
			end else if (c == b64d_pkg::CHAR_MINUS && sextets == '0) begin
				stop_body(b64d_pkg::STATUS_END);
				return;
			end else if (c <= b64d_pkg::CHAR_SPACE) begin
				return;
			end else begin
				stop_body(b64d_pkg::STATUS_ERROR);
				return;
			end
			if (sextets != b64d_pkg::LAST_SEXTET) begin
				acc     = {acc[11:0], sx};
				sextets = sextets + 2'd1;
				return;
			end
			word         = {acc, sx};
			cnt          = b64d_pkg::BYTES_FULL - pads;
			r.byte_hi    = (cnt > 2'd0) ? word[23:16] : 8'h00;
			r.byte_mid   = (cnt > 2'd1) ? word[15:8] : 8'h00;
			r.byte_lo    = (cnt > 2'd2) ? word[7:0] : 8'h00;
			r.byte_count = cnt;
			r.status     = (pads != '0) ? b64d_pkg::STATUS_END : b64d_pkg::STATUS_MORE;
			halted       = (pads != '0);
			clear_quad();
			owed_q.push_back(r);
		endfunction

		function void check_result(b64d_pkg::b64d_result_t got);
			b64d_pkg::b64d_result_t want;
			if (owed_q.size() == 0) begin
				$error("unexpected byte request: %h", got);
				fail_count++;
				return;
			end
			want = owed_q.pop_front();
			if (got.byte_hi !== want.byte_hi) begin
				$error("byte_hi: expected %h, got %h", want.byte_hi, got.byte_hi);
				fail_count++;
			end
			if (got.byte_mid !== want.byte_mid) begin
				$error("byte_mid: expected %h, got %h", want.byte_mid, got.byte_mid);
				fail_count++;
			end
			if (got.byte_lo !== want.byte_lo) begin
				$error("byte_lo: expected %h, got %h", want.byte_lo, got.byte_lo);
				fail_count++;
			end
			if (got.byte_count !== want.byte_count) begin
				$error("byte_count: expected %0d, got %0d", want.byte_count, got.byte_count);
				fail_count++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				fail_count++;
			end
		endfunction

		function int unsigned pending();
			return owed_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	b64d_char_if char_if ();
	b64d_byte_if byte_if ();

	base64_stream_decoder_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_stream (char_if),
		.byte_stream (byte_if)
	);

	quad_scoreboard sb = new();
	char_req_t      req_q[$];
	bit             first_pending;
	int unsigned    burst_left;
	int unsigned    accepted_chars;
	int unsigned    idle_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Note each accepted character before checking results, so the prediction
	// is always ahead of the byte channel whatever the latency.
	always @(posedge clk) begin : monitor
		b64d_pkg::b64d_result_t got;
		if (char_if.valid && char_if.ready) begin
			sb.note_char(char_if.char_in, char_if.first_of_body);
			accepted_chars++;
		end
		if (byte_if.valid && byte_if.ready) begin
			got = {byte_if.byte_hi, byte_if.byte_mid, byte_if.byte_lo,
				byte_if.byte_count, byte_if.status};
			sb.check_result(got);
		end
	end

	// Abort when neither channel moves a request for too long.
	always @(posedge clk) begin
		if ((char_if.valid && char_if.ready) || (byte_if.valid && byte_if.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver: segments of full speed, random stalls and heavy stalls, plus
	// one long hold-off early on so the output buffer fills and the decoder
	// backs up its character channel.
	initial begin : receiver
		int unsigned mode;
		bit          held;
		byte_if.ready = 1'b0;
		held          = 1'b0;
		@(posedge clk);
		forever begin
			if (!held && accepted_chars >= HOLD_AFTER) begin
				held = 1'b1;
				byte_if.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(1, 40)) begin
				case (mode)
					0: byte_if.ready <= 1'b1;
					1: byte_if.ready <= 1'($urandom_range(0, 1));
					default: byte_if.ready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	function automatic logic [7:0] sextet_char(int unsigned v);
		if (v < 26)
			return b64d_pkg::CHAR_UPPER_A + 8'(v);
		else if (v < 52)
			return b64d_pkg::LOWER_OFFSET + 8'(v);
		else if (v < 62)
			return b64d_pkg::DIGIT_OFFSET + 8'(v);
		else if (v == 62)
			return b64d_pkg::CHAR_PLUS;
		else
			return b64d_pkg::CHAR_SLASH;
	endfunction

	task automatic push_req(logic [7:0] c, logic f);
		char_req_t r;
		r.code  = c;
		r.first = f;
		req_q.push_back(r);
	endtask

	// Push one character of the body being built; the first one opens it.
	task automatic push_body(logic [7:0] c);
		push_req(c, first_pending);
		first_pending = 1'b0;
	endtask

	task automatic push_alpha();
		push_body(sextet_char($urandom_range(0, 63)));
	endtask

	// Build one random body: mostly well-formed quads with random content and
	// a random ending, sometimes a broken quad or plain noise.
	task automatic queue_body();
		int unsigned kind;
		int unsigned sel;
		int unsigned nquads;
		logic [7:0]  c;
		first_pending = 1'b1;
		kind          = $urandom_range(0, 19);
		if (kind < 2) begin
			repeat ($urandom_range(1, 6))
				push_req(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
			return;
		end
		nquads = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
		repeat (nquads) begin
			repeat (4) begin
				if ($urandom_range(0, 7) == 0)
					push_body(8'($urandom_range(1, 32)));
				push_alpha();
			end
		end
		if (kind < 5) begin
			// break a quad with NUL, '-' or a character outside the alphabet
			repeat ($urandom_range(1, 3)) push_alpha();
			sel = $urandom_range(0, 2);
			if (sel == 0) begin
				c = b64d_pkg::CHAR_NUL;
			end else if (sel == 1) begin
				c = b64d_pkg::CHAR_MINUS;
			end else begin
				do
					c = 8'($urandom_range(33, 255));
				while (c == b64d_pkg::CHAR_EQUALS || c == b64d_pkg::CHAR_PLUS
					|| c == b64d_pkg::CHAR_SLASH
					|| (c >= b64d_pkg::CHAR_ZERO && c <= b64d_pkg::CHAR_NINE)
					|| (c >= b64d_pkg::CHAR_UPPER_A && c <= b64d_pkg::CHAR_UPPER_Z)
					|| (c >= b64d_pkg::CHAR_LOWER_A && c <= b64d_pkg::CHAR_LOWER_Z));
			end
			push_body(c);
		end else begin
			case ($urandom_range(0, 6))
				0: begin
					repeat (3) push_alpha();
					push_body(b64d_pkg::CHAR_EQUALS);
				end
				1: begin
					repeat (2) push_alpha();
					repeat (2) push_body(b64d_pkg::CHAR_EQUALS);
				end
				2: push_body(b64d_pkg::CHAR_EQUALS);
				3: push_body(b64d_pkg::CHAR_MINUS);
				4: push_body(b64d_pkg::CHAR_NUL);
				5: ; // leave the body open; the next one restarts it
				default: begin
					// pads anywhere after the first sextet, data after pads
					push_alpha();
					repeat (3) begin
						if ($urandom_range(0, 1) == 0)
							push_body(b64d_pkg::CHAR_EQUALS);
						else
							push_alpha();
					end
				end
			endcase
		end
		// trailing characters, mostly dropped by a halted decoder
		repeat ($urandom_range(0, 2)) push_req(8'($urandom_range(0, 255)), 1'b0);
	endtask

	// Send queued requests in bursts of random length with random gaps.
	task automatic drain_requests();
		char_req_t   r;
		int unsigned gap;
		while (req_q.size() > 0) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap > 0) begin
					char_if.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
					: $urandom_range(1, 24);
			end
			r = req_q.pop_front();
			char_if.valid         <= 1'b1;
			char_if.char_in       <= r.code;
			char_if.first_of_body <= r.first;
			@(posedge clk);
			while (!char_if.ready) @(posedge clk);
			burst_left--;
		end
	endtask

	initial begin
		arst_n                = 1'b0;
		char_if.valid         = 1'b0;
		char_if.char_in       = '0;
		char_if.first_of_body = 1'b0;
		burst_left            = 0;
		accepted_chars        = 0;
		idle_cycles           = 0;
		first_pending         = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full quads with skipped characters at both ends of their range
		push_req(sextet_char(0), 1'b1);
		push_req(CHAR_SOH, 1'b0);
		push_req(sextet_char(51), 1'b0);
		push_req(b64d_pkg::CHAR_SPACE, 1'b0);
		push_req(b64d_pkg::CHAR_PLUS, 1'b0);
		push_req(sextet_char(61), 1'b0);
		push_req(sextet_char(25), 1'b0);
		push_req(sextet_char(26), 1'b0);
		push_req(b64d_pkg::CHAR_SLASH, 1'b0);
		push_req(sextet_char(52), 1'b0);
		// data after a pad, two pads end the body, then a dropped character
		push_req(sextet_char(16), 1'b0);
		push_req(b64d_pkg::CHAR_EQUALS, 1'b0);
		push_req(sextet_char(51), 1'b0);
		push_req(b64d_pkg::CHAR_EQUALS, 1'b0);
		push_req(CHAR_MAX, 1'b0);
		// end at the start of a quad: '=', '-' and NUL
		push_req(b64d_pkg::CHAR_EQUALS, 1'b1);
		push_req(b64d_pkg::CHAR_MINUS, 1'b1);
		push_req(b64d_pkg::CHAR_NUL, 1'b1);
		// three pads
		push_req(sextet_char(1), 1'b1);
		repeat (3) push_req(b64d_pkg::CHAR_EQUALS, 1'b0);
		// NUL and '-' inside a quad, then a code above the printable range
		push_req(sextet_char(2), 1'b1);
		push_req(b64d_pkg::CHAR_NUL, 1'b0);
		push_req(sextet_char(3), 1'b1);
		push_req(b64d_pkg::CHAR_MINUS, 1'b0);
		push_req(CHAR_MAX, 1'b1);
		drain_requests();

		while (sb.live_chars < RANDOM_CHARS + 25) begin
			queue_body();
			drain_requests();
		end
		char_if.valid <= 1'b0;

		// wait out the owed results, then give the decoder time to misbehave
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
